// File: sv/categorical_inverse_cdf_sampler_unit_assert.svh
// Assertion macros for the categorical inverse-CDF sampler checker.
`ifndef CATEGORICAL_INVERSE_CDF_SAMPLER_UNIT_ASSERT_SVH
`define CATEGORICAL_INVERSE_CDF_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CICS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cics check failed");

// next-cycle implication, sampled on clk, off during reset
`define CICS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cics check failed");

`endif

// File: sv/cics_pkg.sv
// Shared types, codes and defaults for the categorical inverse-CDF sampler.
`default_nettype none
package cics_pkg;

	localparam int unsigned DEF_MAX_VARS   = 16;
	localparam int unsigned DEF_MAX_GROUPS = 64;
	localparam int unsigned DEF_MAX_LEVELS = 32;

	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned VARIABLE_W = 4;
	localparam int unsigned GROUP_W    = 6;
	localparam int unsigned LEVEL_W    = 5;
	localparam int unsigned WEIGHT_W   = 16;
	localparam int unsigned COUNT_W    = 6;
	localparam int unsigned RANDOM_W   = 16;
	localparam int unsigned CATEGORY_W = 6;
	localparam int unsigned CUM_W      = 21;
	localparam int unsigned PROD_W     = RANDOM_W + CUM_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_SET    = 2'd1,
		OP_SAMPLE = 2'd2
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LD_RD,
		ST_LD_WR,
		ST_SET,
		ST_CNT_RD,
		ST_TOT_RD,
		ST_MUL,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic idle;
		logic lvl_rd;
		logic lvl_wr;
		logic cnt_wr;
		logic cnt_rd;
		logic tot_rd;
		logic mul;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    load_ok;
		logic    var_ok;
		logic    sample_ok;
		logic    scan_more;
		logic    out_free;
	} status_t;

endpackage
`default_nettype wire

// File: sv/categorical_inverse_cdf_sampler_unit.sv
// Top level of the categorical inverse-CDF sampler: controller plus datapath.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid / in_stall | opcode variable group level weight
//          |     |                     | level_count random_value
//  out     | out | out_valid/out_stall | category
//
// Load: read previous sum, write new sum, then return to idle.
// Set-levels: write the level count. Sample: read count, read total, multiply,
// then scan with one cumulative-memory read per level.
// Reset clears control only; both tables are undefined until written.
// A result waiting under out_stall holds the block in its final sample step.
`default_nettype none
module categorical_inverse_cdf_sampler_unit #(
	parameter int unsigned MAX_VARS   = cics_pkg::DEF_MAX_VARS,
	parameter int unsigned MAX_GROUPS = cics_pkg::DEF_MAX_GROUPS,
	parameter int unsigned MAX_LEVELS = cics_pkg::DEF_MAX_LEVELS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [cics_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [cics_pkg::VARIABLE_W-1:0]  variable,
	input  wire logic [cics_pkg::GROUP_W-1:0]     group,
	input  wire logic [cics_pkg::LEVEL_W-1:0]     level,
	input  wire logic [cics_pkg::WEIGHT_W-1:0]    weight,
	input  wire logic [cics_pkg::COUNT_W-1:0]     level_count,
	input  wire logic [cics_pkg::RANDOM_W-1:0]    random_value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [cics_pkg::CATEGORY_W-1:0]       category
);
	import cics_pkg::*;

	cmd_t    cmd;
	status_t sts;

	cics_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	cics_dpath #(
		.MAX_VARS   (MAX_VARS),
		.MAX_GROUPS (MAX_GROUPS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.variable     (variable),
		.group        (group),
		.level        (level),
		.weight       (weight),
		.level_count  (level_count),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.category     (category)
	);

endmodule
`default_nettype wire

// File: sv/cics_ctrl.sv
// Controller state machine: sequences load, set-levels and sample ops.
`default_nettype none
module cics_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cics_pkg::status_t sts,
	output cics_pkg::cmd_t        cmd
);
	import cics_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.op)
					OP_LOAD:   state_d = sts.load_ok ? ST_LD_RD : ST_IDLE;
					OP_SET:    state_d = sts.var_ok ? ST_SET : ST_IDLE;
					OP_SAMPLE: state_d = sts.sample_ok ? ST_CNT_RD : ST_IDLE;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_LD_RD:  state_d = ST_LD_WR;
			ST_LD_WR:  state_d = ST_IDLE;
			ST_SET:    state_d = ST_IDLE;
			ST_CNT_RD: state_d = ST_TOT_RD;
			ST_TOT_RD: state_d = ST_MUL;
			ST_MUL:    state_d = ST_SCAN;
			ST_SCAN: begin
				if (!sts.scan_more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.idle = 1'b1;
			ST_DISPATCH: cmd = '0;
			ST_LD_RD:    cmd.lvl_rd = 1'b1;
			ST_LD_WR:    cmd.lvl_wr = 1'b1;
			ST_SET:      cmd.cnt_wr = 1'b1;
			ST_CNT_RD:   cmd.cnt_rd = 1'b1;
			ST_TOT_RD:   cmd.tot_rd = 1'b1;
			ST_MUL:      cmd.mul = 1'b1;
			ST_SCAN:     cmd.scan_step = sts.scan_more;
			ST_DONE:     cmd.out_load = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/cics_dpath.sv
// Datapath: item capture, cumulative-weight and level-count memories, scan and result register.
`default_nettype none
module cics_dpath #(
	parameter int unsigned MAX_VARS   = cics_pkg::DEF_MAX_VARS,
	parameter int unsigned MAX_GROUPS = cics_pkg::DEF_MAX_GROUPS,
	parameter int unsigned MAX_LEVELS = cics_pkg::DEF_MAX_LEVELS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cics_pkg::cmd_t                   cmd,
	output cics_pkg::status_t                     sts,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [cics_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [cics_pkg::VARIABLE_W-1:0]  variable,
	input  wire logic [cics_pkg::GROUP_W-1:0]     group,
	input  wire logic [cics_pkg::LEVEL_W-1:0]     level,
	input  wire logic [cics_pkg::WEIGHT_W-1:0]    weight,
	input  wire logic [cics_pkg::COUNT_W-1:0]     level_count,
	input  wire logic [cics_pkg::RANDOM_W-1:0]    random_value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [cics_pkg::CATEGORY_W-1:0]       category
);
	import cics_pkg::*;

	localparam int unsigned VW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int unsigned GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int unsigned LW    = $clog2(MAX_LEVELS);
	localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
	localparam int unsigned AW    = VW + GW + LW;

	logic [CUM_W-1:0] cum_mem [2**AW];
	logic [CNT_W-1:0] cnt_mem [2**VW];

	logic [OPCODE_W-1:0]   op_q;
	logic [VARIABLE_W-1:0] var_q;
	logic [GROUP_W-1:0]    grp_q;
	logic [LEVEL_W-1:0]    lvl_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [COUNT_W-1:0]    cnt_in_q;
	logic [RANDOM_W-1:0]   rnd_q;

	logic [CUM_W-1:0]      rd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PROD_W-1:0]     lhs_q;
	logic [CNT_W-1:0]      k_q;
	logic [CATEGORY_W-1:0] category_q;
	logic                  out_valid_q;

	logic                  capture;
	logic [LW-1:0]         rd_lvl;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [CUM_W-1:0]      wr_sum;
	logic [CNT_W-1:0]      cnt_sat;
	logic                  rd_en;

	assign capture  = in_valid && cmd.idle;
	assign in_stall = !cmd.idle;

	always_ff @(posedge clk) begin
		if (capture) begin
			op_q     <= opcode;
			var_q    <= variable;
			grp_q    <= group;
			lvl_q    <= level;
			weight_q <= weight;
			cnt_in_q <= level_count;
			rnd_q    <= random_value;
		end
	end

	always_comb begin
		priority if (cmd.lvl_rd) begin
			rd_lvl = LW'(lvl_q - LEVEL_W'(1));
		end else if (cmd.tot_rd) begin
			rd_lvl = LW'(cnt_q - CNT_W'(1));
		end else if (cmd.scan_step) begin
			rd_lvl = LW'(k_q + CNT_W'(1));
		end else begin
			rd_lvl = '0;
		end
	end

	assign rd_en   = cmd.lvl_rd || cmd.tot_rd || cmd.mul || cmd.scan_step;
	assign rd_addr = {VW'(var_q), GW'(grp_q), rd_lvl};
	assign wr_addr = {VW'(var_q), GW'(grp_q), LW'(lvl_q)};
	assign wr_sum  = ((lvl_q == '0) ? '0 : rd_q) + CUM_W'(weight_q);
	assign cnt_sat = (32'(cnt_in_q) > MAX_LEVELS) ? CNT_W'(MAX_LEVELS) : CNT_W'(cnt_in_q);

	always_ff @(posedge clk) begin
		if (cmd.lvl_wr) begin
			cum_mem[wr_addr] <= wr_sum;
		end
		if (rd_en) begin
			rd_q <= cum_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr) begin
			cnt_mem[VW'(var_q)] <= cnt_sat;
		end
		if (cmd.cnt_rd) begin
			cnt_q <= cnt_mem[VW'(var_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			lhs_q <= PROD_W'(rnd_q) * PROD_W'(rd_q);
			k_q   <= '0;
		end else if (cmd.scan_step) begin
			k_q <= k_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			category_q <= CATEGORY_W'(k_q + CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign category  = category_q;

	always_comb begin
		sts           = '0;
		sts.op        = opcode_t'(op_q);
		sts.var_ok    = 32'(var_q) < MAX_VARS;
		sts.sample_ok = sts.var_ok && (32'(grp_q) < MAX_GROUPS);
		sts.load_ok   = sts.sample_ok && (32'(lvl_q) < MAX_LEVELS);
		sts.scan_more = (k_q < cnt_q) && (lhs_q > {rd_q, {RANDOM_W{1'b0}}});
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule
`default_nettype wire

// File: sv/cics_checker.sv
// Port-level checker for the categorical inverse-CDF sampler, with its bind.
`default_nettype none
`include "categorical_inverse_cdf_sampler_unit_assert.svh"
module cics_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [cics_pkg::CATEGORY_W-1:0]  category
);
	import cics_pkg::*;

	`CICS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`CICS_ASSERT_NEXT(a_cat_hold, out_valid && out_stall, $stable(category))
	`CICS_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
	`CICS_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind categorical_inverse_cdf_sampler_unit cics_checker u_cics_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.category  (category)
);
`default_nettype wire
